### design/ocx_pkg.sv
// ----------------------------------------------------------------------------
// Order crossover package
// Shared widths, sequencer states, read tags and the control bundle that the
// sequencer hands to the parent stores and the two child lanes.
// ----------------------------------------------------------------------------
package ocx_pkg;

    localparam int MAX_CITIES = 64;
    localparam int CITY_W     = $clog2(MAX_CITIES);
    localparam int LEN_W      = CITY_W + 1;

    typedef logic [CITY_W-1:0] ocx_city_t;
    typedef logic [LEN_W-1:0]  ocx_len_t;

    localparam ocx_len_t LEN_MIN   = LEN_W'(2);
    localparam ocx_len_t LEN_MAX   = LEN_W'(MAX_CITIES);
    localparam ocx_len_t LEN_RESET = LEN_W'(32);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_SCAN,
        ST_PREP,
        ST_WALK,
        ST_EMIT
    } ocx_state_t;

    // Meaning of a parent store read, both when it is issued and when its
    // registered data comes back in the following cycle.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_KEY,
        RD_SCAN,
        RD_WALK
    } ocx_rd_t;

    typedef struct packed {
        logic      ld_en;
        ocx_city_t ld_addr;
        logic      start;
        logic      clear;
        ocx_rd_t   mode;
        ocx_city_t scan_addr;
        ocx_rd_t   tag;
        ocx_city_t data_idx;
        logic      walk_start;
        logic      walk_step;
        logic      out_load;
        ocx_city_t out_addr;
        ocx_len_t  n;
    } ocx_ctrl_t;

endpackage

### design/order_crossover_permutation.sv
// ----------------------------------------------------------------------------
// Order crossover of two tours
// Loads two parent tours one position per transaction and emits both
// order-crossover children one position per transaction.
// ----------------------------------------------------------------------------
// A crossover of n cities (n is route_length held to 2..64) takes n input
// transactions at one per cycle. After the last one the block takes no input
// until both children are out: it fetches both prefix keys, scans both parents
// (permutation check, prefix copy and key search), sets up the walk, and walks
// the other parents. It then emits the n results, one per cycle while out_ready
// is high. The single read port of each parent store sets the length of a
// crossover, since every scan and walk step reads both stores once. The cut and
// direction inputs are taken from the transaction that completes the load.
// Configuration writes are always taken and must only happen while idle.
module order_crossover_permutation
    import ocx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  ocx_len_t  route_length,
    input  logic      in_valid,
    output logic      in_ready,
    input  ocx_city_t first_parent_city,
    input  ocx_city_t second_parent_city,
    input  ocx_city_t first_cut,
    input  logic      first_reverse,
    input  ocx_city_t second_cut,
    input  logic      second_reverse,
    output logic      out_valid,
    input  logic      out_ready,
    output ocx_city_t first_child_city,
    output ocx_city_t second_child_city,
    output logic      parents_ok,
    output logic      last_position
);

    ocx_ctrl_t ctrl;
    ocx_city_t first_data;
    ocx_city_t second_data;
    ocx_city_t first_key_addr;
    ocx_city_t second_key_addr;
    ocx_city_t first_walk_addr;
    ocx_city_t second_walk_addr;

    ocx_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .route_length  (route_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .last_position (last_position),
        .ctrl          (ctrl)
    );

    ocx_parents u_parents (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .first_parent_city  (first_parent_city),
        .second_parent_city (second_parent_city),
        .first_key_addr     (first_key_addr),
        .second_key_addr    (second_key_addr),
        .first_walk_addr    (first_walk_addr),
        .second_walk_addr   (second_walk_addr),
        .first_data         (first_data),
        .second_data        (second_data),
        .parents_ok         (parents_ok)
    );

    ocx_lane u_first_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cut        (first_cut),
        .reverse    (first_reverse),
        .own_data   (first_data),
        .other_data (second_data),
        .key_addr   (first_key_addr),
        .walk_addr  (first_walk_addr),
        .child_city (first_child_city)
    );

    ocx_lane u_second_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cut        (second_cut),
        .reverse    (second_reverse),
        .own_data   (second_data),
        .other_data (first_data),
        .key_addr   (second_key_addr),
        .walk_addr  (second_walk_addr),
        .child_city (second_child_city)
    );

endmodule

### design/ocx_seq.sv
// ----------------------------------------------------------------------------
// Order crossover sequencer
// Holds the length register, counts loaded positions, and steps the shared
// read and update unit through key fetch, scan, walk and result output.
// ----------------------------------------------------------------------------
module ocx_seq
    import ocx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  ocx_len_t  route_length,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      last_position,
    output ocx_ctrl_t ctrl
);

    ocx_state_t state_reg, state_next;
    ocx_len_t   len_reg;
    ocx_len_t   cnt_reg, cnt_next;
    ocx_len_t   n_reg, n_next;
    ocx_len_t   idx_reg, idx_next;
    ocx_rd_t    tag_reg, tag_next;
    ocx_city_t  tidx_reg;
    logic       ov_reg, ov_next;
    logic       last_reg, last_next;
    ocx_len_t   n_eff;
    ocx_len_t   cnt_inc;
    logic       out_free;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == ST_LOAD);
    assign out_valid     = ov_reg;
    assign last_position = last_reg;

    always_comb
    begin
        if (len_reg < LEN_MIN)
        begin
            n_eff = LEN_MIN;
        end
        else if (len_reg > LEN_MAX)
        begin
            n_eff = LEN_MAX;
        end
        else
        begin
            n_eff = len_reg;
        end
    end

    assign cnt_inc  = cnt_reg + LEN_W'(1);
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        tag_next   = RD_NONE;
        ov_next    = ov_reg;
        last_next  = last_reg;

        ctrl            = '0;
        ctrl.mode       = RD_NONE;
        ctrl.tag        = tag_reg;
        ctrl.data_idx   = tidx_reg;
        ctrl.n          = n_reg;
        ctrl.ld_addr    = cnt_reg[CITY_W-1:0];
        ctrl.scan_addr  = idx_reg[CITY_W-1:0];
        ctrl.out_addr   = idx_reg[CITY_W-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    ctrl.ld_en = 1'b1;
                    if (cnt_inc >= n_eff)
                    begin
                        ctrl.start = 1'b1;
                        n_next     = n_eff;
                        cnt_next   = '0;
                        state_next = ST_KEY;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_KEY:
            begin
                ctrl.clear = 1'b1;
                ctrl.mode  = RD_KEY;
                tag_next   = RD_KEY;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg < n_reg)
                begin
                    ctrl.mode = RD_SCAN;
                    tag_next  = RD_SCAN;
                    idx_next  = idx_reg + LEN_W'(1);
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                ctrl.walk_start = 1'b1;
                idx_next        = '0;
                state_next      = ST_WALK;
            end
            ST_WALK:
            begin
                if (idx_reg < n_reg)
                begin
                    ctrl.mode      = RD_WALK;
                    ctrl.walk_step = 1'b1;
                    tag_next       = RD_WALK;
                    idx_next       = idx_reg + LEN_W'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (idx_reg < n_reg)
                begin
                    if (out_free)
                    begin
                        ctrl.out_load = 1'b1;
                        ov_next       = 1'b1;
                        last_next     = (idx_reg == n_reg - LEN_W'(1));
                        idx_next      = idx_reg + LEN_W'(1);
                    end
                end
                else if (out_free)
                begin
                    ov_next    = 1'b0;
                    last_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            len_reg   <= LEN_RESET;
            cnt_reg   <= '0;
            n_reg     <= LEN_MIN;
            idx_reg   <= '0;
            tag_reg   <= RD_NONE;
            ov_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            tag_reg   <= tag_next;
            ov_reg    <= ov_next;
            last_reg  <= last_next;
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= route_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tidx_reg <= idx_reg[CITY_W-1:0];
    end

    // A result is only shown while the block is draining the children.
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (state_reg == ST_EMIT))
        else $error("result valid outside the output phase");

    // Taking the final result returns the block to loading.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && last_reg && out_ready) |=> (state_reg == ST_LOAD))
        else $error("block did not return to loading after the final result");

    // The load counter restarts for every crossover.
    a_cnt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> (cnt_reg == '0))
        else $error("load counter not cleared at crossover start");

    // The load counter never passes the largest tour.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (cnt_reg < LEN_MAX))
        else $error("load counter out of range");

endmodule

### design/ocx_parents.sv
// ----------------------------------------------------------------------------
// Order crossover parent stores
// Two parent memories, one read port each, with registered read data, plus the
// permutation check that runs while the sequencer scans both parents.
// ----------------------------------------------------------------------------
module ocx_parents
    import ocx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ocx_ctrl_t ctrl,
    input  ocx_city_t first_parent_city,
    input  ocx_city_t second_parent_city,
    input  ocx_city_t first_key_addr,
    input  ocx_city_t second_key_addr,
    input  ocx_city_t first_walk_addr,
    input  ocx_city_t second_walk_addr,
    output ocx_city_t first_data,
    output ocx_city_t second_data,
    output logic      parents_ok
);

    ocx_city_t              first_mem [MAX_CITIES];
    ocx_city_t              second_mem [MAX_CITIES];
    ocx_city_t              first_rd_reg;
    ocx_city_t              second_rd_reg;
    ocx_city_t              first_addr;
    ocx_city_t              second_addr;
    logic [MAX_CITIES-1:0]  first_seen_reg;
    logic [MAX_CITIES-1:0]  second_seen_reg;
    logic                   first_bad_reg;
    logic                   second_bad_reg;
    logic                   first_hit;
    logic                   second_hit;

    // Child one builds from its own parent one and walks parent two; child two
    // the other way round, so each store serves one lane's key and the other
    // lane's walk.
    always_comb
    begin
        unique case (ctrl.mode)
            RD_KEY:
            begin
                first_addr  = first_key_addr;
                second_addr = second_key_addr;
            end
            RD_WALK:
            begin
                first_addr  = second_walk_addr;
                second_addr = first_walk_addr;
            end
            RD_SCAN, RD_NONE:
            begin
                first_addr  = ctrl.scan_addr;
                second_addr = ctrl.scan_addr;
            end
            default:
            begin
                first_addr  = ctrl.scan_addr;
                second_addr = ctrl.scan_addr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_en)
        begin
            first_mem[ctrl.ld_addr]  <= first_parent_city;
            second_mem[ctrl.ld_addr] <= second_parent_city;
        end
        first_rd_reg  <= first_mem[first_addr];
        second_rd_reg <= second_mem[second_addr];
    end

    assign first_data  = first_rd_reg;
    assign second_data = second_rd_reg;

    assign first_hit  = ({1'b0, first_rd_reg} >= ctrl.n) || first_seen_reg[first_rd_reg];
    assign second_hit = ({1'b0, second_rd_reg} >= ctrl.n) || second_seen_reg[second_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg  <= '0;
            second_seen_reg <= '0;
            first_bad_reg   <= 1'b0;
            second_bad_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            first_seen_reg  <= '0;
            second_seen_reg <= '0;
            first_bad_reg   <= 1'b0;
            second_bad_reg  <= 1'b0;
        end
        else if (ctrl.tag == RD_SCAN)
        begin
            first_seen_reg[first_rd_reg]   <= 1'b1;
            second_seen_reg[second_rd_reg] <= 1'b1;
            if (first_hit)
            begin
                first_bad_reg <= 1'b1;
            end
            if (second_hit)
            begin
                second_bad_reg <= 1'b1;
            end
        end
    end

    assign parents_ok = !(first_bad_reg || second_bad_reg);

endmodule

### design/ocx_lane.sv
// ----------------------------------------------------------------------------
// Order crossover child lane
// Builds one child: copies the own parent's prefix, finds the last prefix
// city in the other parent, then walks the other parent cyclically and
// appends unused cities. Holds the child store and its output register.
// ----------------------------------------------------------------------------
module ocx_lane
    import ocx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ocx_ctrl_t ctrl,
    input  ocx_city_t cut,
    input  logic      reverse,
    input  ocx_city_t own_data,
    input  ocx_city_t other_data,
    output ocx_city_t key_addr,
    output ocx_city_t walk_addr,
    output ocx_city_t child_city
);

    ocx_city_t             child_mem [MAX_CITIES];
    ocx_city_t             cut_reg;
    logic                  rev_reg;
    ocx_city_t             key_reg;
    ocx_city_t             from_reg;
    ocx_city_t             pos_reg;
    logic                  found_reg;
    ocx_len_t              fill_reg;
    logic [MAX_CITIES-1:0] used_reg;
    ocx_city_t             rd_reg;
    logic                  zero_reg;
    ocx_city_t             n_m1;
    ocx_city_t             cut_eff;
    ocx_city_t             pos_step;
    logic                  in_prefix;
    logic                  key_hit;
    logic                  append;
    logic                  wr_en;
    ocx_city_t             wr_addr;
    ocx_city_t             wr_data;

    assign n_m1      = CITY_W'(ctrl.n - LEN_W'(1));
    assign cut_eff   = ({1'b0, cut_reg} >= ctrl.n) ? n_m1 : cut_reg;
    assign key_addr  = cut_eff - CITY_W'(1);
    assign walk_addr = pos_reg;

    assign in_prefix = (ctrl.data_idx < cut_eff);
    // With an empty prefix there is no key and the walk starts at position zero.
    assign key_hit   = (cut_eff != '0) && !found_reg && (other_data == key_reg);
    assign append    = !used_reg[other_data] && (fill_reg < ctrl.n);

    always_comb
    begin
        if (rev_reg)
        begin
            pos_step = (pos_reg == '0) ? n_m1 : pos_reg - CITY_W'(1);
        end
        else
        begin
            pos_step = (pos_reg == n_m1) ? '0 : pos_reg + CITY_W'(1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ctrl.data_idx;
        wr_data = own_data;
        unique case (ctrl.tag)
            RD_SCAN:
            begin
                wr_en = in_prefix;
            end
            RD_WALK:
            begin
                wr_en   = append;
                wr_addr = fill_reg[CITY_W-1:0];
                wr_data = other_data;
            end
            RD_KEY, RD_NONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            found_reg <= 1'b0;
            fill_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            used_reg  <= '0;
            found_reg <= 1'b0;
            fill_reg  <= {1'b0, cut_eff};
        end
        else
        begin
            unique case (ctrl.tag)
                RD_SCAN:
                begin
                    if (in_prefix)
                    begin
                        used_reg[own_data] <= 1'b1;
                    end
                    if (key_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                RD_WALK:
                begin
                    if (append)
                    begin
                        used_reg[other_data] <= 1'b1;
                        fill_reg             <= fill_reg + LEN_W'(1);
                    end
                end
                RD_KEY, RD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cut_reg <= cut;
            rev_reg <= reverse;
        end
        if (ctrl.tag == RD_KEY)
        begin
            key_reg <= own_data;
        end
        if (ctrl.clear)
        begin
            from_reg <= '0;
        end
        else if ((ctrl.tag == RD_SCAN) && key_hit)
        begin
            from_reg <= ctrl.data_idx;
        end
        if (ctrl.walk_start)
        begin
            pos_reg <= from_reg;
        end
        else if (ctrl.walk_step)
        begin
            pos_reg <= pos_step;
        end
        if (wr_en)
        begin
            child_mem[wr_addr] <= wr_data;
        end
        if (ctrl.out_load)
        begin
            rd_reg   <= child_mem[ctrl.out_addr];
            zero_reg <= ({1'b0, ctrl.out_addr} >= fill_reg);
        end
    end

    // Positions the walk never reached read as zero.
    assign child_city = zero_reg ? '0 : rd_reg;

endmodule
